@@ rtl/lrlb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlb_pkg
// Shared types and codes for the resistor-ladder button decoder.
// ----------------------------------------------------------------------------
package lrlb_pkg;

    // number of button codes that can be learned (learn index 0 .. BUTTON_KINDS-1)
    localparam int BUTTON_KINDS = 7;

    // sample kinds
    localparam logic [2:0] KIND_POLL        = 3'd0;
    localparam logic [2:0] KIND_LEARN       = 3'd1;
    localparam logic [2:0] KIND_STEP_START  = 3'd2;
    localparam logic [2:0] KIND_LEARN_BEGIN = 3'd3;
    localparam logic [2:0] KIND_LEARN_END   = 3'd4;
    localparam logic [2:0] KIND_IDLE        = 3'd5;

    // learn status codes
    localparam logic [2:0] LS_NONE    = 3'd0;
    localparam logic [2:0] LS_PENDING = 3'd1;
    localparam logic [2:0] LS_OK      = 3'd2;
    localparam logic [2:0] LS_CLASH   = 3'd3;
    localparam logic [2:0] LS_FULL    = 3'd4;
    localparam logic [2:0] LS_TIMEOUT = 3'd5;
    localparam logic [2:0] LS_DONE    = 3'd6;

    // actions with auto-repeat
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_VOL_UP   = 3'd1;
    localparam logic [2:0] ACT_VOL_DOWN = 3'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MATCH_WINDOW  = 3'd0;
    localparam logic [2:0] CFG_STABLE        = 3'd1;
    localparam logic [2:0] CFG_REPEAT_START  = 3'd2;
    localparam logic [2:0] CFG_REPEAT_EVERY  = 3'd3;
    localparam logic [2:0] CFG_AGREE_MV      = 3'd4;
    localparam logic [2:0] CFG_AGREE_COUNT   = 3'd5;
    localparam logic [2:0] CFG_LEARN_TIMEOUT = 3'd6;

    // search token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic [11:0] mv;
        logic [11:0] bestd;
        logic [2:0]  best;
        logic        hit;
    } lrlb_probe_t;

    // table write request for one cell
    typedef struct packed {
        logic        en;
        logic [11:0] level;
        logic [2:0]  action;
    } lrlb_wr_t;

    function automatic logic [11:0] absdiff12(input logic [11:0] a, input logic [11:0] b);
        absdiff12 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/lrlb_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlb_cell
// One table entry: holds a learned level and action, updates the passing
// search token with the nearest match and hands it to the next cell.
// ----------------------------------------------------------------------------
module lrlb_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                active,
    input  lrlb_pkg::lrlb_wr_t  wr,
    input  lrlb_pkg::lrlb_probe_t probe_in,
    output lrlb_pkg::lrlb_probe_t probe_out
);
    import lrlb_pkg::*;

    logic [11:0] level_reg;
    logic [2:0]  action_reg;
    lrlb_probe_t probe_reg;
    lrlb_probe_t probe_next;
    logic [11:0] lvl_diff;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            level_reg  <= wr.level;
            action_reg <= wr.action;
        end
    end

    // nearest-match update, earlier cell wins ties
    always_comb
    begin
        lvl_diff   = absdiff12(probe_in.mv, level_reg);
        probe_next = probe_in;
        if (active && (lvl_diff < probe_in.bestd))
        begin
            probe_next.bestd = lvl_diff;
            probe_next.best  = action_reg;
            probe_next.hit   = 1'b1;
        end
    end

    // token register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

@@ rtl/learned_resistor_ladder_buttons.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_resistor_ladder_buttons
// Resistor-ladder button decoder with a learned level table held in a chain
// of cells; poll debounce, volume auto-repeat and learn sequencing.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_*      | in        | s_tvalid / s_tready     | s_tuser kind, s_tdata sample
//  m_*      | out       | m_tvalid / m_tready     | m_tdata result
//  cfg_*    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  an item that needs a table lookup (poll off idle level, learn sample that
//  completes agreement) passes ST_PREP, ST_SEARCH and ST_FIN, the token walking
//  one cell per cycle; any other item goes from ST_PREP straight to ST_FIN
//  one item is in work at a time; the next is accepted in the cycle after the
//  result is loaded, also while that result waits
//  reset clears control state and loads the register defaults; the table is
//  empty after reset, no clearing pass
//  a stalled result holds in the output register; cfg_ready is always high
// ----------------------------------------------------------------------------
module learned_resistor_ladder_buttons #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_mv[11:0], sample_ok[12], now_us[60:13], learn_index[63:61]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // action[2:0], learn_status[5:3], learned_mv[17:6],
                                   // learned_count[22:18], table_ready[23]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import lrlb_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREP   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FIN    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [2:0]  kind_reg;
    logic [11:0] mv_reg;
    logic        ok_reg;
    logic [47:0] now_reg;
    logic [2:0]  idx_reg;

    // configuration
    logic [11:0] win_reg;
    logic [3:0]  stable_reg;
    logic [23:0] rstart_reg;
    logic [23:0] revery_reg;
    logic [11:0] agmv_reg;
    logic [3:0]  agcnt_reg;
    logic [9:0]  tmo_reg;

    // decoder state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             map_reg, map_next;
    logic [11:0]      idle_reg, idle_next;
    logic [2:0]       held_reg, held_next;
    logic [3:0]       run_reg, run_next;
    logic [47:0]      since_reg, since_next;
    logic [47:0]      last_reg, last_next;
    logic             lon_reg, lon_next;
    logic [12:0]      prev_reg, prev_next;
    logic [3:0]       agree_reg, agree_next;
    logic [9:0]       tries_reg, tries_next;
    logic [2:0]       code_reg, code_next;

    // lookup result
    logic       srch_hit_reg, srch_hit_next;
    logic [2:0] srch_best_reg, srch_best_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    // chain
    lrlb_probe_t chain [TABLE_DEPTH+1];
    logic        wr_en;

    // working signals
    logic [12:0] mv_plus_win;
    logic        release_lvl;
    logic        learn_below;
    logic        agree_hit;
    logic [3:0]  agree_inc;
    logic        agree_done;
    logic [3:0]  run_inc;
    logic [9:0]  tries_inc;
    logic [47:0] hold_el;
    logic [47:0] rep_el;
    logic        need_search;
    logic        fin_go;
    logic [2:0]  act;
    logic [2:0]  status;
    logic [11:0] rec;
    logic [2:0]  cur;
    logic [31:0] cnt_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // request latch
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            mv_reg   <= s_tdata[11:0];
            ok_reg   <= s_tdata[12];
            now_reg  <= s_tdata[60:13];
            idx_reg  <= s_tdata[63:61];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= 12'd90;
            stable_reg <= 4'd4;
            rstart_reg <= 24'd600000;
            revery_reg <= 24'd140000;
            agmv_reg   <= 12'd25;
            agcnt_reg  <= 4'd6;
            tmo_reg    <= 10'd400;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MATCH_WINDOW:  win_reg    <= cfg_data[11:0];
                CFG_STABLE:        stable_reg <= cfg_data[3:0];
                CFG_REPEAT_START:  rstart_reg <= cfg_data;
                CFG_REPEAT_EVERY:  revery_reg <= cfg_data;
                CFG_AGREE_MV:      agmv_reg   <= cfg_data[11:0];
                CFG_AGREE_COUNT:   agcnt_reg  <= cfg_data[3:0];
                CFG_LEARN_TIMEOUT: tmo_reg    <= cfg_data[9:0];
                default:           ;
            endcase
        end
    end

    // search token launch
    always_comb
    begin
        chain[0].valid = (state_reg == ST_PREP) && need_search;
        chain[0].mv    = mv_reg;
        chain[0].bestd = win_reg;
        chain[0].best  = ACT_NONE;
        chain[0].hit   = 1'b0;
    end

    // cell chain, one table entry per cell
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            lrlb_wr_t cell_wr;
            logic     cell_active;

            always_comb
            begin
                cell_active   = CNT_W'(gi) < count_reg;
                cell_wr.en    = wr_en && (count_reg == CNT_W'(gi));
                cell_wr.level = mv_reg;
                cell_wr.action = code_reg + 3'd1;
            end

            lrlb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .active    (cell_active),
                .wr        (cell_wr),
                .probe_in  (chain[gi]),
                .probe_out (chain[gi+1])
            );
        end
    endgenerate

    // shared comparisons on the latched request
    always_comb
    begin
        mv_plus_win = {1'b0, mv_reg} + {1'b0, win_reg};
        release_lvl = mv_plus_win > {1'b0, idle_reg};
        learn_below = ok_reg && (mv_plus_win < {1'b0, idle_reg});
        agree_hit   = prev_reg[12] && (absdiff12(mv_reg, prev_reg[11:0]) < agmv_reg);
        agree_inc   = (agree_reg < 4'd15) ? (agree_reg + 4'd1) : agree_reg;
        agree_done  = learn_below && agree_hit && (agree_inc >= agcnt_reg);
        run_inc     = (run_reg < 4'd15) ? (run_reg + 4'd1) : run_reg;
        tries_inc   = (tries_reg < 10'd1023) ? (tries_reg + 10'd1) : tries_reg;
        hold_el     = now_reg - since_reg;
        rep_el      = now_reg - last_reg;
        need_search = ((kind_reg == KIND_POLL) && map_reg && ok_reg && !release_lvl) ||
                      ((kind_reg == KIND_LEARN) && lon_reg && agree_done);
        fin_go      = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    end

    // sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        map_next       = map_reg;
        idle_next      = idle_reg;
        held_next      = held_reg;
        run_next       = run_reg;
        since_next     = since_reg;
        last_next      = last_reg;
        lon_next       = lon_reg;
        prev_next      = prev_reg;
        agree_next     = agree_reg;
        tries_next     = tries_reg;
        code_next      = code_reg;
        srch_hit_next  = srch_hit_reg;
        srch_best_next = srch_best_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        act            = ACT_NONE;
        status         = LS_NONE;
        rec            = 12'd0;
        cur            = ACT_NONE;
        cnt_ext        = 32'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                srch_hit_next  = 1'b0;
                srch_best_next = ACT_NONE;
                state_next     = need_search ? ST_SEARCH : ST_FIN;
            end
            ST_SEARCH:
            begin
                if (chain[TABLE_DEPTH].valid)
                begin
                    srch_hit_next  = chain[TABLE_DEPTH].hit;
                    srch_best_next = chain[TABLE_DEPTH].best;
                    state_next     = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                    unique case (kind_reg)
                        KIND_POLL:
                        begin
                            if (map_reg && ok_reg)
                            begin
                                cur = release_lvl ? ACT_NONE : srch_best_reg;
                                if (cur != held_reg)
                                begin
                                    if (run_inc < stable_reg)
                                    begin
                                        run_next = run_inc;
                                    end
                                    else
                                    begin
                                        run_next   = 4'd0;
                                        held_next  = cur;
                                        since_next = now_reg;
                                        last_next  = 48'd0;
                                        act        = cur;
                                    end
                                end
                                else
                                begin
                                    run_next = 4'd0;
                                    if (((held_reg == ACT_VOL_UP) || (held_reg == ACT_VOL_DOWN)) &&
                                        (hold_el > {24'd0, rstart_reg}) &&
                                        (rep_el > {24'd0, revery_reg}))
                                    begin
                                        last_next = now_reg;
                                        act       = held_reg;
                                    end
                                end
                            end
                        end
                        KIND_LEARN:
                        begin
                            if (lon_reg)
                            begin
                                if (agree_done)
                                begin
                                    agree_next = agree_inc;
                                    lon_next   = 1'b0;
                                    if (srch_hit_reg)
                                    begin
                                        status = LS_CLASH;
                                        rec    = mv_reg;
                                    end
                                    else if (count_reg >= CNT_W'(TABLE_DEPTH))
                                    begin
                                        status = LS_FULL;
                                    end
                                    else
                                    begin
                                        wr_en      = 1'b1;
                                        count_next = count_reg + CNT_W'(1);
                                        status     = LS_OK;
                                        rec        = mv_reg;
                                    end
                                end
                                else
                                begin
                                    if (learn_below)
                                    begin
                                        agree_next = agree_hit ? agree_inc : 4'd0;
                                        prev_next  = {1'b1, mv_reg};
                                    end
                                    else
                                    begin
                                        agree_next = 4'd0;
                                        prev_next  = 13'd0;
                                    end
                                    tries_next = tries_inc;
                                    if (tries_inc >= tmo_reg)
                                    begin
                                        lon_next = 1'b0;
                                        status   = LS_TIMEOUT;
                                    end
                                    else
                                    begin
                                        status = LS_PENDING;
                                    end
                                end
                            end
                        end
                        KIND_STEP_START:
                        begin
                            if (idx_reg >= 3'(BUTTON_KINDS))
                            begin
                                lon_next = 1'b0;
                                status   = LS_DONE;
                            end
                            else
                            begin
                                lon_next   = 1'b1;
                                code_next  = idx_reg;
                                prev_next  = 13'd0;
                                agree_next = 4'd0;
                                tries_next = 10'd0;
                                status     = LS_PENDING;
                            end
                        end
                        KIND_LEARN_BEGIN:
                        begin
                            count_next = '0;
                            idle_next  = ok_reg ? mv_reg : 12'd0;
                            map_next   = 1'b0;
                            lon_next   = 1'b0;
                        end
                        KIND_LEARN_END:
                        begin
                            map_next = (count_reg != '0);
                            lon_next = 1'b0;
                        end
                        KIND_IDLE:
                        begin
                            idle_next = ok_reg ? mv_reg : 12'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                    cnt_ext        = 32'(count_next);
                    out_valid_next = 1'b1;
                    out_data_next  = {map_next, cnt_ext[4:0], rec, status, act};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            map_reg       <= 1'b0;
            idle_reg      <= 12'd0;
            held_reg      <= ACT_NONE;
            run_reg       <= 4'd0;
            since_reg     <= 48'd0;
            last_reg      <= 48'd0;
            lon_reg       <= 1'b0;
            prev_reg      <= 13'd0;
            agree_reg     <= 4'd0;
            tries_reg     <= 10'd0;
            code_reg      <= 3'd0;
            srch_hit_reg  <= 1'b0;
            srch_best_reg <= ACT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            map_reg       <= map_next;
            idle_reg      <= idle_next;
            held_reg      <= held_next;
            run_reg       <= run_next;
            since_reg     <= since_next;
            last_reg      <= last_next;
            lon_reg       <= lon_next;
            prev_reg      <= prev_next;
            agree_reg     <= agree_next;
            tries_reg     <= tries_next;
            code_reg      <= code_next;
            srch_hit_reg  <= srch_hit_next;
            srch_best_reg <= srch_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/lrlb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlb_checker
// Port-level checks of the button decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lrlb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import lrlb_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // one request in work: ready drops after an accept
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // a poll action never comes with a learn status
    a_action_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] != ACT_NONE)) |-> (m_tdata[5:3] == LS_NONE))
        else $error("action and learn status together");

    // level only reported on ok or clash
    a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[5:3] != LS_OK) && (m_tdata[5:3] != LS_CLASH))
            |-> (m_tdata[17:6] == 12'd0))
        else $error("learned level outside ok or clash");

endmodule

bind learned_resistor_ladder_buttons lrlb_checker u_lrlb_checker (.*);
